// ===== rtl/core/sha1_pkg.sv =====
// sha1 package: state type, round constants, initial chaining values
// and the round function helpers shared by the sha1 stream hash files
// depends on nothing
`default_nettype none

package sha1_pkg;

   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned BLOCK_BITS  = BLOCK_BYTES * 8;
   localparam int unsigned NUM_WORDS   = 5;
   localparam int unsigned COUNT_W     = 61;
   localparam int unsigned ROUND_W     = $clog2(ROUNDS);
   localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);

   localparam logic [2:0] LAST_IDX = 3'(NUM_WORDS - 1);
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [31:0] H_INIT [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } sha1_state_type;

   function automatic logic [31:0] sha1_f(input logic [ROUND_W-1:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
      if (rnd < ROUND_W'(20)) begin
         return (b & c) | (~b & d);
      end else if (rnd < ROUND_W'(40)) begin
         return b ^ c ^ d;
      end else if (rnd < ROUND_W'(60)) begin
         return (b & c) | (b & d) | (c & d);
      end else begin
         return b ^ c ^ d;
      end
   endfunction

   function automatic logic [31:0] sha1_k(input logic [ROUND_W-1:0] rnd);
      if (rnd < ROUND_W'(20)) begin
         return K_0;
      end else if (rnd < ROUND_W'(40)) begin
         return K_1;
      end else if (rnd < ROUND_W'(60)) begin
         return K_2;
      end else begin
         return K_3;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_if.sv =====
// sha1 channel interfaces: byte request channel and digest word response
// channel, each with valid/ready and a source and sink modport
// depends on nothing
`default_nettype none

interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       finish;

   modport source(output valid, output data_byte, output has_byte, output finish,
                  input ready);
   modport sink(input valid, input data_byte, input has_byte, input finish,
                output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source(output valid, output digest_word, output word_index,
                  output last_word, input ready);
   modport sink(input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1_stream_hash.sv =====
// sha1 stream hash top level: byte fill, padding sequencer and one shared
// round unit iterated 80 times per block
// depends on sha1_pkg and sha1_if
//
// channel    dir  payload                              item
// req_chan   in   data_byte, has_byte, finish          one message byte
// rsp_chan   out  digest_word, word_index, last_word   one digest word
//
// a message byte is taken in idle; the 64th byte of a block starts its
// compression (80 rounds of the single round unit, one per cycle, then the
// chaining add); finish pads one byte per cycle up to the block end,
// compresses once or twice, then offers five digest words
// req_chan.ready is low while a block compresses, and from a finish until
// the last digest word is taken; a stalled rsp_chan holds its word
// reset is synchronous; chaining words return to their initial values
`default_nettype none

module sha1_stream_hash
   import sha1_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sha1_req_if.sink    req_chan,
   sha1_rsp_if.source  rsp_chan
);

   sha1_state_type state_ff, state_in;

   logic [BLOCK_BITS-1:0] w_ff, w_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ROUND_W-1:0]    round_ff, round_in;
   logic [2:0]            idx_ff, idx_in;
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [31:0]           h_ff [NUM_WORDS];
   logic [31:0]           h_in [NUM_WORDS];
   logic                  fin_ff, fin_in;
   logic                  first_ff, first_in;
   logic                  zfill_ff, zfill_in;
   logic                  lendone_ff, lendone_in;

   logic [31:0] w0, w2, w8, w13, w_new, t_sum;
   logic [63:0] len_bits, len_shift;
   logic [7:0]  pad_byte;
   logic        go_round;

   assign w0  = w_ff[BLOCK_BITS-1 -: 32];
   assign w2  = w_ff[BLOCK_BITS-1-2*32 -: 32];
   assign w8  = w_ff[BLOCK_BITS-1-8*32 -: 32];
   assign w13 = w_ff[BLOCK_BITS-1-13*32 -: 32];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         count_ff   <= '0;
         round_ff   <= '0;
         idx_ff     <= '0;
         fin_ff     <= 1'b0;
         first_ff   <= 1'b0;
         zfill_ff   <= 1'b0;
         lendone_ff <= 1'b0;
         h_ff       <= H_INIT;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         round_ff   <= round_in;
         idx_ff     <= idx_in;
         fin_ff     <= fin_in;
         first_ff   <= first_in;
         zfill_ff   <= zfill_in;
         lendone_ff <= lendone_in;
         h_ff       <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   always_comb begin
      state_in   = state_ff;
      w_in       = w_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      fin_in     = fin_ff;
      first_in   = first_ff;
      zfill_in   = zfill_ff;
      lendone_in = lendone_ff;
      h_in       = h_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      e_in       = e_ff;
      go_round   = 1'b0;

      req_chan.ready       = 1'b0;
      rsp_chan.valid       = 1'b0;
      rsp_chan.digest_word = h_ff[idx_ff];
      rsp_chan.word_index  = idx_ff;
      rsp_chan.last_word   = (idx_ff == LAST_IDX);

      w_new = {w13 ^ w8 ^ w2 ^ w0};
      w_new = {w_new[30:0], w_new[31]};
      t_sum = {a_ff[26:0], a_ff[31:27]} + sha1_f(round_ff, b_ff, c_ff, d_ff)
              + e_ff + sha1_k(round_ff) + w0;

      len_bits  = {count_ff, 3'b000};
      len_shift = len_bits >> {~pos_ff[2:0], 3'b000};
      if (first_ff) begin
         pad_byte = PAD_BYTE;
      end else if (!zfill_ff && (pos_ff[POS_W-1:3] == '1)) begin
         pad_byte = len_shift[7:0];
      end else begin
         pad_byte = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               fin_in     = req_chan.finish;
               first_in   = req_chan.finish;
               zfill_in   = 1'b0;
               lendone_in = 1'b0;
               if (req_chan.has_byte) begin
                  w_in     = {w_ff[BLOCK_BITS-9:0], req_chan.data_byte};
                  pos_in   = pos_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_chan.has_byte && (pos_ff == '1)) begin
                  go_round = 1'b1;
               end else if (req_chan.finish) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            w_in   = {w_ff[BLOCK_BITS-9:0], pad_byte};
            pos_in = pos_ff + 1'b1;
            if (first_ff) begin
               first_in = 1'b0;
               zfill_in = (pos_ff[POS_W-1:3] == '1);
            end
            if (!first_ff && !zfill_ff && (pos_ff == '1)) begin
               lendone_in = 1'b1;
            end
            if (pos_ff == '1) begin
               go_round = 1'b1;
            end
         end
         ST_ROUND: begin
            a_in     = t_sum;
            b_in     = a_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            d_in     = c_ff;
            e_in     = d_ff;
            w_in     = {w_ff[BLOCK_BITS-33:0], w_new};
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0]  = h_ff[0] + a_ff;
            h_in[1]  = h_ff[1] + b_ff;
            h_in[2]  = h_ff[2] + c_ff;
            h_in[3]  = h_ff[3] + d_ff;
            h_in[4]  = h_ff[4] + e_ff;
            zfill_in = 1'b0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lendone_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               if (idx_ff == LAST_IDX) begin
                  h_in       = H_INIT;
                  count_in   = '0;
                  fin_in     = 1'b0;
                  lendone_in = 1'b0;
                  idx_in     = '0;
                  state_in   = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (go_round) begin
         state_in = ST_ROUND;
         round_in = '0;
         a_in     = h_ff[0];
         b_in     = h_ff[1];
         c_in     = h_ff[2];
         d_in     = h_ff[3];
         e_in     = h_ff[4];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_checker.sv =====
// sha1 port checker: watches the request and response channels of the
// stream hash top level; bound to sha1_stream_hash below
// depends on sha1_pkg
`default_nettype none

module sha1_checker
   import sha1_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_finish,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while digest words pending");

   a_finish_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_finish) |=> !req_ready)
      else $error("ready high right after finish item");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == LAST_IDX)))
      else $error("last_word does not match word_index");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1)))
      else $error("digest word index did not advance");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled digest word changed");

endmodule

bind sha1_stream_hash sha1_checker u_sha1_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_finish      (req_chan.finish),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_digest_word (rsp_chan.digest_word),
   .rsp_word_index  (rsp_chan.word_index),
   .rsp_last_word   (rsp_chan.last_word)
);

`default_nettype wire
